// File: hdl/mqsb_pkg.sv
// Package for the multi-queue shared buffer.
// Holds the operation and status codes, the controller state type and the
// command group from the controller to the datapath. Depends on nothing.
package mqsb_pkg;

  // Operation codes carried on func_i.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Result status codes carried on status_o.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Width of the queue number field and the number of queues it can name.
  localparam int unsigned QID_W   = 2;
  localparam int unsigned NUM_QID = 4;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;   // a word is accepted this cycle: issue the first phase
    logic finish;  // second phase completes and loads the result register
  } cmd_t;

endpackage

// File: hdl/mqsb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read.
// Used for the slot data store and the link store. No dependencies.
module mqsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/mqsb_ctrl.sv
// Controller of the multi-queue shared buffer: a two-state sequencer and the
// output valid flag. Depends on mqsb_pkg.
module mqsb_ctrl
  import mqsb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register can be loaded when empty or when its word leaves now.
  assign out_free = !out_valid_q || out_ready_i;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output and command logic.
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o.start  = 1'b0;
    cmd_o.finish = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_FINISH: begin
        cmd_o.finish = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Result valid flag: set when a result is loaded, cleared when taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/mqsb_dp.sv
// Datapath of the multi-queue shared buffer: queue head and tail pointers,
// free list head, fresh-slot count, slot and link stores, result register.
// Depends on mqsb_pkg and mqsb_ram.
module mqsb_dp
  import mqsb_pkg::*;
#(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  input  logic               func_i,
  input  logic [QID_W-1:0]   queue_id_i,
  input  logic signed [31:0] value_in_i,
  output logic signed [31:0] value_out_o,
  output logic [1:0]         status_o
);

  // Pointer width holds every slot index plus the null value SLOTS.
  localparam int unsigned PW = $clog2(SLOTS + 1);
  localparam int unsigned AW = $clog2(SLOTS);
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  logic [PW-1:0] head_q [NUM_QID];
  logic [PW-1:0] tail_q [NUM_QID];
  logic [PW-1:0] free_head_q;
  logic [PW-1:0] fresh_q;

  // Operation captured at acceptance.
  logic              func_q;
  logic [QID_W-1:0]  qid_q;
  logic [31:0]       value_q;
  logic [PW-1:0]     slot_q;
  logic              ok_q;
  logic              fresh_hit_q;

  logic signed [31:0] value_out_q;
  logic [1:0]         status_q;

  logic          q_ok;
  logic          is_deq;
  logic [PW-1:0] sel_head;
  logic [PW-1:0] sel_tail;
  logic [PW-1:0] start_slot;
  logic          start_ok;
  logic [PW-1:0] fin_head;
  logic [PW-1:0] next_ptr;
  logic          commit;

  logic          link_we;
  logic [AW-1:0] link_waddr;
  logic [PW-1:0] link_wdata;
  logic [PW-1:0] link_rdata;
  logic          data_we;
  logic [31:0]   data_rdata;

  // First phase: pick the slot and decide whether the operation succeeds.
  always_comb begin
    q_ok       = 7'(queue_id_i) < 7'(QUEUES);
    is_deq     = (func_i == FUNC_DEQ);
    sel_head   = head_q[queue_id_i];
    sel_tail   = tail_q[queue_id_i];
    start_slot = is_deq ? sel_head : free_head_q;
    start_ok   = q_ok && (start_slot != NIL);
  end

  // Second phase: a slot at or above the fresh count was never allocated,
  // so its link was never written and the next slot is taken in its place.
  always_comb begin
    fin_head = head_q[qid_q];
    next_ptr = fresh_hit_q ? (slot_q + PW'(1)) : link_rdata;
    commit   = cmd_i.finish && ok_q;
  end

  // Link store write port: chain behind the old tail in the first phase,
  // rewrite the moved slot's own link in the second.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = sel_tail[AW-1:0];
    link_wdata = free_head_q;
    if (cmd_i.start && start_ok && !is_deq && (sel_head != NIL)) begin
      link_we    = 1'b1;
      link_waddr = sel_tail[AW-1:0];
      link_wdata = free_head_q;
    end else if (commit) begin
      link_we    = 1'b1;
      link_waddr = slot_q[AW-1:0];
      link_wdata = (func_q == FUNC_DEQ) ? free_head_q : NIL;
    end
  end

  assign data_we = commit && (func_q == FUNC_ENQ);

  mqsb_ram #(
    .WIDTH (PW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (cmd_i.start),
    .raddr_i (start_slot[AW-1:0]),
    .rdata_o (link_rdata)
  );

  mqsb_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (data_we),
    .waddr_i (slot_q[AW-1:0]),
    .wdata_i (value_q),
    .re_i    (cmd_i.start),
    .raddr_i (start_slot[AW-1:0]),
    .rdata_o (data_rdata)
  );

  // Capture of the accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (cmd_i.start) begin
      ok_q <= start_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q      <= func_i;
      qid_q       <= queue_id_i;
      value_q     <= value_in_i;
      slot_q      <= start_slot;
      fresh_hit_q <= (start_slot >= fresh_q);
    end
  end

  // Pointer state updated when an operation commits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QID; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
      free_head_q <= '0;
      fresh_q     <= '0;
    end else if (commit) begin
      if (func_q == FUNC_ENQ) begin
        free_head_q <= next_ptr;
        if (fin_head == NIL) begin
          head_q[qid_q] <= slot_q;
        end
        tail_q[qid_q] <= slot_q;
        if (fresh_hit_q) begin
          fresh_q <= fresh_q + PW'(1);
        end
      end else begin
        head_q[qid_q] <= next_ptr;
        free_head_q   <= slot_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (ok_q) begin
        status_q    <= ST_OK;
        value_out_q <= (func_q == FUNC_DEQ) ? data_rdata : 32'sd0;
      end else begin
        status_q    <= (func_q == FUNC_DEQ) ? ST_EMPTY : ST_FULL;
        value_out_q <= 32'sd0;
      end
    end
  end

  assign value_out_o = value_out_q;
  assign status_o    = status_q;

endmodule

// File: hdl/multi_queue_shared_buffer.sv
// Top level of the multi-queue shared buffer: several FIFO queues in one
// linked slot store with a free list. Depends on mqsb_pkg, mqsb_ctrl, mqsb_dp.
//
//   channel | handshake               | fields
//   --------+-------------------------+-----------------------------
//   in      | in_valid_i / in_ready_o | func_i, queue_id_i, value_in_i
//   out     | out_valid_o/out_ready_i | value_out_o, status_o
//
// Each word runs in a first and a second phase: the accept cycle reads the
// link and slot stores at the chosen slot, then S_FINISH writes the link
// store again and loads the result register. The single write port of the
// link store sets this split. A word is accepted while an earlier result
// still waits; the second phase stalls only while the result register is
// full and not being taken. Reset is asynchronous; no clearing pass is
// needed, as slots never yet allocated are tracked by a fill count.
module multi_queue_shared_buffer
  import mqsb_pkg::*;
#(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned QUEUES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [QID_W-1:0]   queue_id_i,
  input  logic signed [31:0] value_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_out_o,
  output logic [1:0]         status_o
);

  cmd_t cmd;

  mqsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mqsb_dp #(
    .SLOTS  (SLOTS),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .func_i      (func_i),
    .queue_id_i  (queue_id_i),
    .value_in_i  (value_in_i),
    .value_out_o (value_out_o),
    .status_o    (status_o)
  );

endmodule
